@@ design/cps_pkg.sv @@
package cps_pkg;
  localparam int unsigned COORD_W      = 24;
  localparam int unsigned RSQ_W        = 52;
  localparam int unsigned ID_W         = 16;
  localparam int unsigned DIST_W       = 26;
  localparam int unsigned PARAM_W      = 13;
  localparam int unsigned DEF_FRAC     = 12;
  localparam int unsigned DIFF_W       = COORD_W + 1;
  localparam int unsigned PROD_W       = 2 * DIFF_W;
  localparam int unsigned DOT_W        = PROD_W + 2;
  localparam int unsigned DSQ_W        = 2 * DIFF_W + 2;
  localparam int unsigned SQRT_W       = DSQ_W / 2;
endpackage

@@ design/closest_point_on_segment_core.sv @@
// closest point on a 3d segment, fully pipelined
// command channel: drive the segment, query point, radius_sq and seg_id with
// start high; the item is taken at that edge. busy is always low, so an item
// can be taken in every cycle.
// result channel: done is high for exactly one cycle with hit, distance,
// closest_x/y/z, seg_param and hit_seg_id; the receiver cannot stall, and
// results leave in the order the items came in.
// pipeline, from start to done: three stages for the dot products, one
// quotient bit per stage in the divider, three stages for the
// interpolation and squared distance, one root bit per stage in the square
// root, then the output register.
// throughput: one item per cycle.
// reset: rst clears every valid bit; items in flight are dropped and done
// stays low until a new item passes through.
module closest_point_on_segment_core #(
  parameter int unsigned COORD_FRAC_BITS = cps_pkg::DEF_FRAC
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [cps_pkg::COORD_W-1:0]  seg_a_x,
  input  logic signed [cps_pkg::COORD_W-1:0]  seg_a_y,
  input  logic signed [cps_pkg::COORD_W-1:0]  seg_a_z,
  input  logic signed [cps_pkg::COORD_W-1:0]  seg_b_x,
  input  logic signed [cps_pkg::COORD_W-1:0]  seg_b_y,
  input  logic signed [cps_pkg::COORD_W-1:0]  seg_b_z,
  input  logic signed [cps_pkg::COORD_W-1:0]  query_x,
  input  logic signed [cps_pkg::COORD_W-1:0]  query_y,
  input  logic signed [cps_pkg::COORD_W-1:0]  query_z,
  input  logic        [cps_pkg::RSQ_W-1:0]    radius_sq,
  input  logic        [cps_pkg::ID_W-1:0]     seg_id,
  output logic                                done,
  output logic                                hit,
  output logic        [cps_pkg::DIST_W-1:0]   distance,
  output logic signed [cps_pkg::COORD_W-1:0]  closest_x,
  output logic signed [cps_pkg::COORD_W-1:0]  closest_y,
  output logic signed [cps_pkg::COORD_W-1:0]  closest_z,
  output logic        [cps_pkg::PARAM_W-1:0]  seg_param,
  output logic        [cps_pkg::ID_W-1:0]     hit_seg_id
);
  localparam int unsigned CW  = cps_pkg::COORD_W;
  localparam int unsigned DW  = cps_pkg::DIFF_W;
  localparam int unsigned PW  = cps_pkg::PROD_W;
  localparam int unsigned OW  = cps_pkg::DOT_W;
  localparam int unsigned QW  = COORD_FRAC_BITS + 1;
  localparam int unsigned RW  = OW + 1;
  localparam int unsigned SW  = cps_pkg::DSQ_W;
  localparam int unsigned TW  = cps_pkg::SQRT_W;
  localparam int unsigned NDV = COORD_FRAC_BITS;

  typedef logic signed [CW-1:0] crd_t;
  typedef logic signed [DW-1:0] dif_t;

  typedef enum logic [1:0] {SEL_MID, SEL_START, SEL_END} sel_t;

  typedef struct packed {
    crd_t [2:0]                 a;
    crd_t [2:0]                 x;
    dif_t [2:0]                 u;
    logic [cps_pkg::RSQ_W-1:0]  r2;
    logic [cps_pkg::ID_W-1:0]   id;
  } side_t;

  assign busy = 1'b0;

  // stage 1: differences
  logic  v1;
  side_t s1;
  dif_t [2:0] v1d;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= start;
    s1.a  <= {seg_a_z, seg_a_y, seg_a_x};
    s1.x  <= {query_z, query_y, query_x};
    s1.u[0] <= DW'(seg_b_x) - DW'(seg_a_x);
    s1.u[1] <= DW'(seg_b_y) - DW'(seg_a_y);
    s1.u[2] <= DW'(seg_b_z) - DW'(seg_a_z);
    v1d[0]  <= DW'(query_x) - DW'(seg_a_x);
    v1d[1]  <= DW'(query_y) - DW'(seg_a_y);
    v1d[2]  <= DW'(query_z) - DW'(seg_a_z);
    s1.r2 <= radius_sq;
    s1.id <= seg_id;
  end

  // stage 2: products
  logic  v2;
  side_t s2;
  logic signed [PW-1:0] p_uv [3];
  logic signed [PW-1:0] p_uu [3];
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
    s2 <= s1;
    for (int k = 0; k < 3; k++) begin
      p_uv[k] <= s1.u[k] * v1d[k];
      p_uu[k] <= s1.u[k] * s1.u[k];
    end
  end

  // stage 3: sums and case decision
  logic  v3;
  side_t s3;
  logic signed [OW-1:0] c1_3, c2_3;
  logic signed [OW-1:0] c1_s, c2_s;
  always_comb begin
    c1_s = OW'(p_uv[0]) + OW'(p_uv[1]) + OW'(p_uv[2]);
    c2_s = OW'(p_uu[0]) + OW'(p_uu[1]) + OW'(p_uu[2]);
  end
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
    s3   <= s2;
    c1_3 <= c1_s;
    c2_3 <= c2_s;
  end

  // divider: one quotient bit per stage
  typedef struct packed {
    side_t           sd;
    logic [RW-1:0]   rem;
    logic [OW-1:0]   den;
    logic [QW-1:0]   q;
    sel_t            sel;   // interior, clamp to start or clamp to end
  } div_t;

  logic [NDV:0] dv;
  div_t         ds [NDV+1];

  always_comb begin
    ds[0].sd  = s3;
    ds[0].rem = RW'(unsigned'(c1_3));
    ds[0].den = unsigned'(c2_3);
    ds[0].q   = '0;
    if (c1_3 <= 0)         ds[0].sel = SEL_START;
    else if (c2_3 <= c1_3) ds[0].sel = SEL_END;
    else                   ds[0].sel = SEL_MID;
    dv[0] = v3;
  end

  for (genvar g = 0; g < NDV; g++) begin : g_div
    logic [RW-1:0] sh;
    assign sh = {ds[g].rem[RW-2:0], 1'b0};
    always_ff @(posedge clk) begin
      if (rst) dv[g+1] <= 1'b0;
      else     dv[g+1] <= dv[g];
      ds[g+1].sd  <= ds[g].sd;
      ds[g+1].den <= ds[g].den;
      ds[g+1].sel <= ds[g].sel;
      if (sh >= RW'(ds[g].den)) begin
        ds[g+1].rem <= sh - RW'(ds[g].den);
        ds[g+1].q   <= {ds[g].q[QW-2:0], 1'b1};
      end else begin
        ds[g+1].rem <= sh;
        ds[g+1].q   <= {ds[g].q[QW-2:0], 1'b0};
      end
    end
  end

  // interpolation stage: t and u*t
  logic  v4;
  side_t s4;
  logic [QW-1:0] t4;
  sel_t          sel4;
  logic signed [DW+QW:0] ut4 [3];
  logic [QW-1:0] t_sel;
  always_comb begin
    unique case (ds[NDV].sel)
      SEL_START: t_sel = '0;
      SEL_END:   t_sel = QW'(1) << COORD_FRAC_BITS;
      default:   t_sel = ds[NDV].q;
    endcase
  end
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else     v4 <= dv[NDV];
    s4   <= ds[NDV].sd;
    t4   <= t_sel;
    sel4 <= ds[NDV].sel;
    for (int k = 0; k < 3; k++)
      ut4[k] <= ds[NDV].sd.u[k] * $signed({1'b0, ds[NDV].q});
  end

  // closest point and offset from query
  logic  v5;
  side_t s5;
  logic [QW-1:0] t5;
  crd_t [2:0]    p5;
  dif_t [2:0]    e5;
  crd_t [2:0]    p_c;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      unique case (sel4)
        SEL_START: p_c[k] = s4.a[k];
        SEL_END:   p_c[k] = CW'(DW'(s4.a[k]) + s4.u[k]);
        default:   p_c[k] = CW'(DW'(s4.a[k]) + DW'(ut4[k] >>> COORD_FRAC_BITS));
      endcase
    end
  end
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else     v5 <= v4;
    s5 <= s4;
    t5 <= t4;
    p5 <= p_c;
    for (int k = 0; k < 3; k++)
      e5[k] <= DW'(s4.x[k]) - DW'(p_c[k]);
  end

  // squares
  logic  v6;
  side_t s6;
  logic [QW-1:0] t6;
  crd_t [2:0]    p6;
  logic [PW-1:0] sq6 [3];
  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else     v6 <= v5;
    s6 <= s5;
    t6 <= t5;
    p6 <= p5;
    for (int k = 0; k < 3; k++)
      sq6[k] <= PW'(e5[k] * e5[k]);
  end

  // square root: one result bit per stage, hit compare on entry
  typedef struct packed {
    logic [SW-1:0]           rad;
    logic [TW+1:0]           rem;
    logic [TW-1:0]           root;
    logic                    hit;
    crd_t [2:0]              p;
    logic [QW-1:0]           t;
    logic [cps_pkg::ID_W-1:0] id;
  } sq_t;

  logic [TW:0] qv;
  sq_t         qs [TW+1];
  logic [SW-1:0] dsq;

  always_comb begin
    dsq = SW'(sq6[0]) + SW'(sq6[1]) + SW'(sq6[2]);
    qs[0].rad  = dsq;
    qs[0].rem  = '0;
    qs[0].root = '0;
    qs[0].hit  = (dsq <= SW'(s6.r2));
    qs[0].p    = p6;
    qs[0].t    = t6;
    qs[0].id   = s6.id;
    qv[0]      = v6;
  end

  for (genvar g = 0; g < TW; g++) begin : g_sqrt
    logic [TW+1:0] rr, trial;
    assign rr    = {qs[g].rem[TW-1:0], qs[g].rad[SW-1 -: 2]};
    assign trial = {qs[g].root, 2'b01};
    always_ff @(posedge clk) begin
      if (rst) qv[g+1] <= 1'b0;
      else     qv[g+1] <= qv[g];
      qs[g+1].rad <= {qs[g].rad[SW-3:0], 2'b00};
      qs[g+1].hit <= qs[g].hit;
      qs[g+1].p   <= qs[g].p;
      qs[g+1].t   <= qs[g].t;
      qs[g+1].id  <= qs[g].id;
      if (rr >= trial) begin
        qs[g+1].rem  <= rr - trial;
        qs[g+1].root <= {qs[g].root[TW-2:0], 1'b1};
      end else begin
        qs[g+1].rem  <= rr;
        qs[g+1].root <= {qs[g].root[TW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= qv[TW];
    hit        <= qs[TW].hit;
    distance   <= cps_pkg::DIST_W'(qs[TW].root);
    closest_x  <= qs[TW].p[0];
    closest_y  <= qs[TW].p[1];
    closest_z  <= qs[TW].p[2];
    seg_param  <= cps_pkg::PARAM_W'(qs[TW].t);
    hit_seg_id <= qs[TW].id;
  end

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    v6 |-> ##(TW+1) done) else $error("result lost in root pipe");
  a_interior_t: assert property (@(posedge clk) disable iff (rst)
    (dv[NDV] && ds[NDV].sel == SEL_MID) |=> (t4 < (QW'(1) << COORD_FRAC_BITS)))
    else $error("interior t reached end");
  a_start_t: assert property (@(posedge clk) disable iff (rst)
    (v4 && sel4 == SEL_START) |-> (t4 == '0)) else $error("start clamp t");
  a_busy: assert property (@(posedge clk) !busy) else $error("busy high");
endmodule
